/* hw/rtl/am6502_pkg.sv */
// Shared types and codes for the 6502 addressing-mode unit.
// Used by am6502_seq and cpu6502_address_mode_unit; depends on nothing else.
`default_nettype none

package am6502_pkg;

  // Operation codes of an input transaction
  localparam logic OP_START = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Addressing modes
  localparam logic [3:0] MODE_IMP  = 4'd0;
  localparam logic [3:0] MODE_IMM  = 4'd1;
  localparam logic [3:0] MODE_ZP   = 4'd2;
  localparam logic [3:0] MODE_ZPX  = 4'd3;
  localparam logic [3:0] MODE_ZPY  = 4'd4;
  localparam logic [3:0] MODE_ABS  = 4'd5;
  localparam logic [3:0] MODE_ABSX = 4'd6;
  localparam logic [3:0] MODE_ABSY = 4'd7;
  localparam logic [3:0] MODE_IND  = 4'd8;
  localparam logic [3:0] MODE_INDX = 4'd9;
  localparam logic [3:0] MODE_INDY = 4'd10;
  localparam logic [3:0] MODE_REL  = 4'd11;

  // Result kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // Page masks and branch offset sign bit
  localparam logic [15:0] PAGE_MASK  = 16'hFF00;
  localparam logic [15:0] ZP_MASK    = 16'h00FF;
  localparam logic [7:0]  SIGN_MASK  = 8'h80;

  // One result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] request_address;
    logic [15:0] abs_address;
    logic [15:0] rel_offset;
    logic [7:0]  fetched_value;
    logic [15:0] next_pc;
    logic        page_crossed;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/am6502_seq.sv */
// Address resolution sequencer: holds the per-instruction state and forms
// one result per transaction. Depends on am6502_pkg.
`default_nettype none

module am6502_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 op,
  input  wire logic [3:0]           mode,
  input  wire logic [15:0]          prog_counter,
  input  wire logic [7:0]           index_x,
  input  wire logic [7:0]           index_y,
  input  wire logic [7:0]           accum,
  input  wire logic [15:0]          prior_abs_address,
  input  wire logic [15:0]          prior_rel_offset,
  input  wire logic [7:0]           prior_fetched,
  input  wire logic [7:0]           bus_data,
  output am6502_pkg::result_t       res
);

  // Reads received so far within one resolution
  typedef enum logic [3:0] {
    STEP_FIRST  = 4'b0001,
    STEP_SECOND = 4'b0010,
    STEP_THIRD  = 4'b0100,
    STEP_FOURTH = 4'b1000
  } step_t;

  logic        busy, busy_next;
  step_t       step, step_next;
  logic [3:0]  saved_mode, saved_mode_next;
  logic [15:0] saved_pc, saved_pc_next;
  logic [7:0]  saved_x, saved_x_next;
  logic [7:0]  saved_y, saved_y_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [7:0]  pointer_low, pointer_low_next;
  logic [15:0] kept_abs, kept_abs_next;
  logic [15:0] kept_rel, kept_rel_next;
  logic [7:0]  kept_fetched, kept_fetched_next;

  logic [15:0] pc_plus1, pc_plus2;
  logic [7:0]  zp_index, zp_sum;
  logic [7:0]  abs_index;
  logic [15:0] abs_sum, indy_sum, ptr, ptr_hi_addr;
  logic [7:0]  indx_lo, indx_hi, first_plus1;

  function automatic am6502_pkg::result_t make_done(
    input logic [15:0] a,
    input logic [15:0] r,
    input logic [7:0]  f,
    input logic [15:0] pc,
    input logic        pg
  );
    am6502_pkg::result_t d;
    d                 = '0;
    d.kind            = am6502_pkg::KIND_DONE;
    d.abs_address     = a;
    d.rel_offset      = r;
    d.fetched_value   = f;
    d.next_pc         = pc;
    d.page_crossed    = pg;
    return d;
  endfunction

  function automatic am6502_pkg::result_t make_request(input logic [15:0] a);
    am6502_pkg::result_t d;
    d                 = '0;
    d.kind            = am6502_pkg::KIND_REQUEST;
    d.request_address = a;
    return d;
  endfunction

  // Shared address arithmetic
  always_comb begin
    pc_plus1    = saved_pc + 16'd1;
    pc_plus2    = saved_pc + 16'd2;
    zp_index    = (saved_mode == am6502_pkg::MODE_ZPX) ? saved_x :
                  (saved_mode == am6502_pkg::MODE_ZPY) ? saved_y : 8'h00;
    zp_sum      = bus_data + zp_index;
    abs_index   = (saved_mode == am6502_pkg::MODE_ABSX) ? saved_x :
                  (saved_mode == am6502_pkg::MODE_ABSY) ? saved_y : 8'h00;
    abs_sum     = {bus_data, first_byte} + {8'h00, abs_index};
    indy_sum    = {bus_data, pointer_low} + {8'h00, saved_y};
    ptr         = {second_byte, first_byte};
    // Indirect pointer wraps within its page on a low byte of all ones
    ptr_hi_addr = (first_byte == 8'hFF) ? (ptr & am6502_pkg::PAGE_MASK) : (ptr + 16'd1);
    indx_lo     = bus_data + saved_x;
    indx_hi     = first_byte + saved_x + 8'd1;
    first_plus1 = first_byte + 8'd1;
  end

  // Next state and result for the current transaction
  always_comb begin
    busy_next         = busy;
    step_next         = step;
    saved_mode_next   = saved_mode;
    saved_pc_next     = saved_pc;
    saved_x_next      = saved_x;
    saved_y_next      = saved_y;
    first_byte_next   = first_byte;
    second_byte_next  = second_byte;
    pointer_low_next  = pointer_low;
    kept_abs_next     = kept_abs;
    kept_rel_next     = kept_rel;
    kept_fetched_next = kept_fetched;
    res               = '0;
    res.kind          = am6502_pkg::KIND_IGNORED;

    if (op == am6502_pkg::OP_START) begin
      // Latch the instruction context and begin (or restart) resolution
      saved_mode_next   = mode;
      saved_pc_next     = prog_counter;
      saved_x_next      = index_x;
      saved_y_next      = index_y;
      kept_abs_next     = prior_abs_address;
      kept_rel_next     = prior_rel_offset;
      kept_fetched_next = prior_fetched;
      first_byte_next   = 8'h00;
      second_byte_next  = 8'h00;
      pointer_low_next  = 8'h00;
      step_next         = STEP_FIRST;
      busy_next         = 1'b1;
      case (mode)
        am6502_pkg::MODE_IMP: begin
          kept_fetched_next = accum;
          busy_next         = 1'b0;
          res = make_done(prior_abs_address, prior_rel_offset, accum, prog_counter, 1'b0);
        end
        am6502_pkg::MODE_IMM: begin
          kept_abs_next = prog_counter;
          busy_next     = 1'b0;
          res = make_done(prog_counter, prior_rel_offset, prior_fetched,
                          prog_counter + 16'd1, 1'b0);
        end
        am6502_pkg::MODE_ZP, am6502_pkg::MODE_ZPX, am6502_pkg::MODE_ZPY,
        am6502_pkg::MODE_ABS, am6502_pkg::MODE_ABSX, am6502_pkg::MODE_ABSY,
        am6502_pkg::MODE_IND, am6502_pkg::MODE_INDX, am6502_pkg::MODE_INDY,
        am6502_pkg::MODE_REL: begin
          res = make_request(prog_counter);
        end
        default: begin
          // Undefined mode: finish at once with the context unchanged
          busy_next = 1'b0;
          res = make_done(prior_abs_address, prior_rel_offset, prior_fetched,
                          prog_counter, 1'b0);
        end
      endcase
    end else if (busy) begin
      case (saved_mode)
        am6502_pkg::MODE_ZP, am6502_pkg::MODE_ZPX, am6502_pkg::MODE_ZPY: begin
          first_byte_next = bus_data;
          kept_abs_next   = {8'h00, zp_sum} & am6502_pkg::ZP_MASK;
          busy_next       = 1'b0;
          step_next       = STEP_FIRST;
          res = make_done({8'h00, zp_sum}, kept_rel, kept_fetched, pc_plus1, 1'b0);
        end
        am6502_pkg::MODE_REL: begin
          first_byte_next = bus_data;
          kept_rel_next   = ((bus_data & am6502_pkg::SIGN_MASK) != 8'h00) ?
                            {8'hFF, bus_data} : {8'h00, bus_data};
          busy_next       = 1'b0;
          step_next       = STEP_FIRST;
          res = make_done(kept_abs, kept_rel_next, kept_fetched, pc_plus1, 1'b0);
        end
        am6502_pkg::MODE_ABS, am6502_pkg::MODE_ABSX, am6502_pkg::MODE_ABSY: begin
          if (step == STEP_FIRST) begin
            first_byte_next = bus_data;
            step_next       = STEP_SECOND;
            res = make_request(pc_plus1);
          end else begin
            second_byte_next = bus_data;
            kept_abs_next    = abs_sum;
            busy_next        = 1'b0;
            step_next        = STEP_FIRST;
            res = make_done(abs_sum, kept_rel, kept_fetched, pc_plus2,
                            abs_sum[15:8] != bus_data);
          end
        end
        am6502_pkg::MODE_IND: begin
          case (step)
            STEP_FIRST: begin
              first_byte_next = bus_data;
              step_next       = STEP_SECOND;
              res = make_request(pc_plus1);
            end
            STEP_SECOND: begin
              second_byte_next = bus_data;
              step_next        = STEP_THIRD;
              res = make_request({bus_data, first_byte});
            end
            STEP_THIRD: begin
              pointer_low_next = bus_data;
              step_next        = STEP_FOURTH;
              res = make_request(ptr_hi_addr);
            end
            default: begin
              kept_abs_next = {bus_data, pointer_low};
              busy_next     = 1'b0;
              step_next     = STEP_FIRST;
              res = make_done({bus_data, pointer_low}, kept_rel, kept_fetched,
                              pc_plus2, 1'b0);
            end
          endcase
        end
        am6502_pkg::MODE_INDX: begin
          case (step)
            STEP_FIRST: begin
              first_byte_next = bus_data;
              step_next       = STEP_SECOND;
              res = make_request({8'h00, indx_lo});
            end
            STEP_SECOND: begin
              pointer_low_next = bus_data;
              step_next        = STEP_THIRD;
              res = make_request({8'h00, indx_hi});
            end
            default: begin
              kept_abs_next = {bus_data, pointer_low};
              busy_next     = 1'b0;
              step_next     = STEP_FIRST;
              res = make_done({bus_data, pointer_low}, kept_rel, kept_fetched,
                              pc_plus1, 1'b0);
            end
          endcase
        end
        am6502_pkg::MODE_INDY: begin
          case (step)
            STEP_FIRST: begin
              first_byte_next = bus_data;
              step_next       = STEP_SECOND;
              res = make_request({8'h00, bus_data});
            end
            STEP_SECOND: begin
              pointer_low_next = bus_data;
              step_next        = STEP_THIRD;
              res = make_request({8'h00, first_plus1});
            end
            default: begin
              kept_abs_next = indy_sum;
              busy_next     = 1'b0;
              step_next     = STEP_FIRST;
              res = make_done(indy_sum, kept_rel, kept_fetched, pc_plus1,
                              indy_sum[15:8] != bus_data);
            end
          endcase
        end
        default: begin
          // Modes that never wait for data: drop the resolution
          busy_next = 1'b0;
          step_next = STEP_FIRST;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_FIRST;
    end else if (en) begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  // Instruction context
  always_ff @(posedge clk) begin
    if (en) begin
      saved_mode   <= saved_mode_next;
      saved_pc     <= saved_pc_next;
      saved_x      <= saved_x_next;
      saved_y      <= saved_y_next;
      first_byte   <= first_byte_next;
      second_byte  <= second_byte_next;
      pointer_low  <= pointer_low_next;
      kept_abs     <= kept_abs_next;
      kept_rel     <= kept_rel_next;
      kept_fetched <= kept_fetched_next;
    end
  end

  // Sequencer checks
  a_idle_at_first_step: assert property (@(posedge clk) disable iff (rst)
    !busy |-> step == STEP_FIRST)
    else $error("idle sequencer holds a nonzero step");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    en && res.kind == am6502_pkg::KIND_DONE |=> !busy)
    else $error("sequencer stays busy after a done result");

  a_request_stays_busy: assert property (@(posedge clk) disable iff (rst)
    en && res.kind == am6502_pkg::KIND_REQUEST |=> busy)
    else $error("sequencer went idle after a read request");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    en && op == am6502_pkg::OP_START |=> step == STEP_FIRST)
    else $error("start did not restart the step count");

  a_ignored_when_idle: assert property (@(posedge clk) disable iff (rst)
    en && op == am6502_pkg::OP_READ && !busy |-> res.kind == am6502_pkg::KIND_IGNORED)
    else $error("read data while idle was not ignored");

endmodule

`default_nettype wire

/* hw/rtl/cpu6502_address_mode_unit.sv */
// An accepted input transaction has its result in the output register in the cycle after it is taken.
// Throughput: one transaction per clock; set by the single-pass step logic in am6502_seq
// feeding one output register, which accepts a new transaction whenever it is empty or drained.
// Reset (synchronous, active high) clears busy, the step count and the output valid.
// Top level of the 6502 addressing-mode unit; depends on am6502_pkg and am6502_seq.
`default_nettype none

module cpu6502_address_mode_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [3:0]  mode,
  input  wire logic [15:0] prog_counter,
  input  wire logic [7:0]  index_x,
  input  wire logic [7:0]  index_y,
  input  wire logic [7:0]  accum,
  input  wire logic [15:0] prior_abs_address,
  input  wire logic [15:0] prior_rel_offset,
  input  wire logic [7:0]  prior_fetched,
  input  wire logic [7:0]  bus_data,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [15:0]      request_address,
  output logic [15:0]      abs_address,
  output logic [15:0]      rel_offset,
  output logic [7:0]       fetched_value,
  output logic [15:0]      next_pc,
  output logic             page_crossed
);

  logic                in_take;
  am6502_pkg::result_t step_res;
  am6502_pkg::result_t res_reg;

  // Accept while the output register is empty or being drained
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  am6502_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .en                (in_take),
    .op                (op),
    .mode              (mode),
    .prog_counter      (prog_counter),
    .index_x           (index_x),
    .index_y           (index_y),
    .accum             (accum),
    .prior_abs_address (prior_abs_address),
    .prior_rel_offset  (prior_rel_offset),
    .prior_fetched     (prior_fetched),
    .bus_data          (bus_data),
    .res               (step_res)
  );

  // Output valid: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      res_reg <= step_res;
    end
  end

  assign kind            = res_reg.kind;
  assign request_address = res_reg.request_address;
  assign abs_address     = res_reg.abs_address;
  assign rel_offset      = res_reg.rel_offset;
  assign fetched_value   = res_reg.fetched_value;
  assign next_pc         = res_reg.next_pc;
  assign page_crossed    = res_reg.page_crossed;

endmodule

`default_nettype wire
